/* rtl/scaled_matrix_to_quaternion_assert.svh */
// Assertion macros for the checker file of this block.
`ifndef SCALED_MATRIX_TO_QUATERNION_ASSERT_SVH
`define SCALED_MATRIX_TO_QUATERNION_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define SMTQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define SMTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/smtq_pkg.sv */
package smtq_pkg;

	localparam int IN_BITS    = 32;
	localparam int QDEPTH     = 4;
	localparam int QPTR_BITS  = 2;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_ZSCALE = 2'd1,
		ST_BADARG = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		PV_TRACE = 2'd0,
		PV_X     = 2'd1,
		PV_Y     = 2'd2,
		PV_Z     = 2'd3
	} pivot_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_MSTART,
		BK_MWAIT,
		BK_TRACE,
		BK_ARG,
		BK_RSTART,
		BK_RWAIT,
		BK_SCALE,
		BK_QSTART,
		BK_QWAIT,
		BK_OUT
	} bstate_t;

	// One accepted transaction as it waits between the front and the back.
	typedef struct packed {
		logic [2:0][2:0][IN_BITS-1:0] mat;
		logic [2:0][IN_BITS-1:0]      scl;
		logic                         zscale;
	} item_t;

endpackage

/* rtl/scaled_matrix_to_quaternion.sv */
// Channel   Direction  Handshake            Contents
// input     in         push / full          c0_r0 .. c2_r2, scale_x, scale_y, scale_z
// result    out        empty / pop          quat_w .. quat_z, pivot_case, status
//
// One transaction takes twelve fixed-point divisions on a single shared restoring
// divider, one quotient bit per cycle, plus one root on a two-bit-per-cycle unit;
// a zero scale skips the arithmetic. The divider sets the rate. Reset is
// asynchronous, active low, and clears control. A four-deep queue lets inputs keep
// arriving while the back end works or while a finished result waits to be popped.
module scaled_matrix_to_quaternion #(
	parameter int FRAC_BITS = 16,
	parameter int WORD_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [31:0]        c0_r0,
	input  logic [31:0]        c0_r1,
	input  logic [31:0]        c0_r2,
	input  logic [31:0]        c1_r0,
	input  logic [31:0]        c1_r1,
	input  logic [31:0]        c1_r2,
	input  logic [31:0]        c2_r0,
	input  logic [31:0]        c2_r1,
	input  logic [31:0]        c2_r2,
	input  logic [31:0]        scale_x,
	input  logic [31:0]        scale_y,
	input  logic [31:0]        scale_z,
	output logic               empty,
	input  logic               pop,
	output logic signed [31:0] quat_w,
	output logic signed [31:0] quat_x,
	output logic signed [31:0] quat_y,
	output logic signed [31:0] quat_z,
	output logic [1:0]         pivot_case,
	output logic [1:0]         status
);

	smtq_pkg::item_t front_item;
	smtq_pkg::item_t head_item;
	logic            q_empty;
	logic            q_pop;

	// The front end packs the transaction and flags a zero scale up front, so the
	// back end can skip all arithmetic for it.
	smtq_front u_front (
		.c0_r0   (c0_r0),
		.c0_r1   (c0_r1),
		.c0_r2   (c0_r2),
		.c1_r0   (c1_r0),
		.c1_r1   (c1_r1),
		.c1_r2   (c1_r2),
		.c2_r0   (c2_r0),
		.c2_r1   (c2_r1),
		.c2_r2   (c2_r2),
		.scale_x (scale_x),
		.scale_y (scale_y),
		.scale_z (scale_z),
		.item    (front_item)
	);

	// Decoupling queue; full here is the input channel's backpressure.
	smtq_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (front_item),
		.full   (full),
		.pop    (q_pop),
		.dout   (head_item),
		.empty  (q_empty)
	);

	// The back end divides the columns, picks the pivot, takes the root and forms
	// the quaternion, then parks the result in its output register.
	smtq_back #(.W(WORD_BITS), .F(FRAC_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (!q_empty),
		.item       (head_item),
		.item_pop   (q_pop),
		.quat_w     (quat_w),
		.quat_x     (quat_x),
		.quat_y     (quat_y),
		.quat_z     (quat_z),
		.pivot_case (pivot_case),
		.status     (status),
		.empty      (empty),
		.pop        (pop)
	);

endmodule

/* rtl/smtq_front.sv */
module smtq_front (
	input  logic [smtq_pkg::IN_BITS-1:0] c0_r0,
	input  logic [smtq_pkg::IN_BITS-1:0] c0_r1,
	input  logic [smtq_pkg::IN_BITS-1:0] c0_r2,
	input  logic [smtq_pkg::IN_BITS-1:0] c1_r0,
	input  logic [smtq_pkg::IN_BITS-1:0] c1_r1,
	input  logic [smtq_pkg::IN_BITS-1:0] c1_r2,
	input  logic [smtq_pkg::IN_BITS-1:0] c2_r0,
	input  logic [smtq_pkg::IN_BITS-1:0] c2_r1,
	input  logic [smtq_pkg::IN_BITS-1:0] c2_r2,
	input  logic [smtq_pkg::IN_BITS-1:0] scale_x,
	input  logic [smtq_pkg::IN_BITS-1:0] scale_y,
	input  logic [smtq_pkg::IN_BITS-1:0] scale_z,
	output smtq_pkg::item_t              item
);

	// Saturation never turns a nonzero scale into zero, so the raw check suffices.
	always_comb begin
		item.mat[0][0] = c0_r0;
		item.mat[0][1] = c0_r1;
		item.mat[0][2] = c0_r2;
		item.mat[1][0] = c1_r0;
		item.mat[1][1] = c1_r1;
		item.mat[1][2] = c1_r2;
		item.mat[2][0] = c2_r0;
		item.mat[2][1] = c2_r1;
		item.mat[2][2] = c2_r2;
		item.scl[0]    = scale_x;
		item.scl[1]    = scale_y;
		item.scl[2]    = scale_z;
		item.zscale    = (scale_x == '0) || (scale_y == '0) || (scale_z == '0);
	end

endmodule

/* rtl/smtq_fifo.sv */
module smtq_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  smtq_pkg::item_t din,
	output logic            full,
	input  logic            pop,
	output smtq_pkg::item_t dout,
	output logic            empty
);

	smtq_pkg::item_t                   mem_q [smtq_pkg::QDEPTH];
	logic [smtq_pkg::QPTR_BITS-1:0]    wr_q;
	logic [smtq_pkg::QPTR_BITS-1:0]    rd_q;
	logic [smtq_pkg::QPTR_BITS:0]      cnt_q;
	logic                              do_push;
	logic                              do_pop;

	assign full    = (cnt_q == (smtq_pkg::QPTR_BITS+1)'(smtq_pkg::QDEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/smtq_div.sv */
module smtq_div #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [W-1:0] num,
	input  logic signed [W-1:0] den,
	output logic                done,
	output logic signed [W-1:0] res
);

	localparam int N  = W + F;
	localparam int CW = $clog2(N);

	logic [W:0]     rem_q;
	logic [N-1:0]   dvd_q;
	logic [N-1:0]   quo_q;
	logic [W-1:0]   d_q;
	logic           neg_q;
	logic [CW-1:0]  cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [W-1:0]   nmag;
	logic [W-1:0]   dmag;
	logic [W:0]     rem_sh;
	logic           ge;
	logic [W:0]     rem_nx;
	logic [W-1:0]   lim;
	logic [W-1:0]   qs;
	logic           last;

	// Restoring division of (|num| << F) by |den|, one quotient bit per cycle.
	always_comb begin
		nmag   = num[W-1] ? W'(-num) : W'(num);
		dmag   = den[W-1] ? W'(-den) : W'(den);
		rem_sh = {rem_q[W-1:0], dvd_q[N-1]};
		ge     = (rem_sh >= {1'b0, d_q});
		rem_nx = ge ? (rem_sh - {1'b0, d_q}) : rem_sh;
		last   = (cnt_q == CW'(N - 1));
		lim    = {1'b0, {(W-1){1'b1}}} + W'(neg_q);
		qs     = (quo_q > N'(lim)) ? lim : quo_q[W-1:0];
		res    = neg_q ? $signed(-qs) : $signed(qs);
	end

	assign done = done_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= {nmag, {F{1'b0}}};
			quo_q <= '0;
			d_q   <= dmag;
			neg_q <= num[W-1] ^ den[W-1];
		end else if (busy_q) begin
			rem_q <= rem_nx;
			dvd_q <= {dvd_q[N-2:0], 1'b0};
			quo_q <= {quo_q[N-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

endmodule

/* rtl/smtq_sqrt.sv */
module smtq_sqrt #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [W-1:0] arg,
	output logic                done,
	output logic [(W+F+1)/2-1:0] root
);

	localparam int R  = (W + F + 1) / 2;
	localparam int VB = 2 * R;
	localparam int CW = $clog2(R + 1);

	logic [VB-1:0]  v_q;
	logic [R+2:0]   rem_q;
	logic [R-1:0]   root_q;
	logic [CW-1:0]  cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [R+2:0]   rem_sh;
	logic [R+2:0]   trial;
	logic           ge;
	logic           last;

	// Digit-by-digit root of (arg << F), two radicand bits per cycle.
	always_comb begin
		rem_sh = {rem_q[R:0], v_q[VB-1:VB-2]};
		trial  = {1'b0, root_q, 2'b01};
		ge     = (rem_sh >= trial);
		last   = (cnt_q == CW'(R - 1));
	end

	assign done = done_q;
	assign root = root_q;

	always_ff @(posedge clk) begin
		if (start) begin
			v_q    <= VB'({arg, {F{1'b0}}});
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			v_q    <= {v_q[VB-3:0], 2'b00};
			rem_q  <= ge ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[R-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

endmodule

/* rtl/smtq_back.sv */
module smtq_back #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	input  smtq_pkg::item_t        item,
	output logic                   item_pop,
	output logic signed [31:0]     quat_w,
	output logic signed [31:0]     quat_x,
	output logic signed [31:0]     quat_y,
	output logic signed [31:0]     quat_z,
	output logic [1:0]             pivot_case,
	output logic [1:0]             status,
	output logic                   empty,
	input  logic                   pop
);

	localparam int R = (W + F + 1) / 2;
	localparam logic signed [63:0] WMAX  = (64'sd1 <<< (W - 1)) - 64'sd1;
	localparam logic signed [63:0] WMIN  = -WMAX - 64'sd1;
	localparam logic signed [63:0] ONE64 = ((64'sd1 <<< F) > WMAX) ? WMAX : (64'sd1 <<< F);

	function automatic logic signed [W-1:0] sat_w(input logic signed [63:0] v);
		logic signed [63:0] c;
		c = v;
		if (v > WMAX) begin
			c = WMAX;
		end else if (v < WMIN) begin
			c = WMIN;
		end
		return W'(c);
	endfunction

	function automatic logic signed [31:0] out32(input logic signed [W-1:0] v);
		logic signed [63:0] e;
		e = 64'(v);
		if (e > 64'sd2147483647) begin
			e = 64'sd2147483647;
		end else if (e < -64'sd2147483648) begin
			e = -64'sd2147483648;
		end
		return 32'(e);
	endfunction

	function automatic logic signed [63:0] x64(input logic signed [W-1:0] v);
		return 64'(v);
	endfunction

	smtq_pkg::bstate_t     st_q;
	smtq_pkg::bstate_t     st_d;
	smtq_pkg::item_t       ent_q;
	logic [1:0]            col_q;
	logic [1:0]            row_q;
	logic [1:0]            k_q;
	logic signed [W-1:0]   m_q [3][3];
	logic signed [W-1:0]   q_q [4];
	logic signed [W-1:0]   trace_q;
	logic                  xbig_q;
	logic                  ybig_q;
	logic signed [W-1:0]   dx_q;
	logic signed [W-1:0]   dy_q;
	logic signed [W-1:0]   dz_q;
	logic signed [W-1:0]   pxy_q;
	logic signed [W-1:0]   pxz_q;
	logic signed [W-1:0]   pyz_q;
	logic signed [W-1:0]   arg_q;
	logic signed [W-1:0]   s_q;
	smtq_pkg::pivot_t      pc_q;
	smtq_pkg::status_t     stat_q;
	logic signed [31:0]    ow_q;
	logic signed [31:0]    ox_q;
	logic signed [31:0]    oy_q;
	logic signed [31:0]    oz_q;
	logic [1:0]            opc_q;
	logic [1:0]            ost_q;
	logic                  oval_q;

	logic                  div_start;
	logic                  div_done;
	logic signed [W-1:0]   div_num;
	logic signed [W-1:0]   div_den;
	logic signed [W-1:0]   div_res;
	logic                  sq_start;
	logic                  sq_done;
	logic [R-1:0]          sq_root;
	logic                  out_load;
	smtq_pkg::pivot_t      pc_d;
	logic signed [W-1:0]   arg_d;
	logic signed [W-1:0]   qnum;
	logic signed [W-1:0]   s_d;
	logic [1:0]            tgt;

	smtq_div #(.W(W), .F(F)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.res    (div_res)
	);

	smtq_sqrt #(.W(W), .F(F)) u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.arg    (arg_q),
		.done   (sq_done),
		.root   (sq_root)
	);

	// Numerator of the three closing divisions, by pivot and slot.
	always_comb begin
		qnum = dx_q;
		case (pc_q)
			smtq_pkg::PV_TRACE: begin
				case (k_q)
					2'd0:    qnum = dx_q;
					2'd1:    qnum = dy_q;
					default: qnum = dz_q;
				endcase
			end
			smtq_pkg::PV_X: begin
				case (k_q)
					2'd0:    qnum = dx_q;
					2'd1:    qnum = pxy_q;
					default: qnum = pxz_q;
				endcase
			end
			smtq_pkg::PV_Y: begin
				case (k_q)
					2'd0:    qnum = dy_q;
					2'd1:    qnum = pxy_q;
					default: qnum = pyz_q;
				endcase
			end
			default: begin
				case (k_q)
					2'd0:    qnum = dz_q;
					2'd1:    qnum = pxz_q;
					default: qnum = pyz_q;
				endcase
			end
		endcase
		tgt = (k_q < pc_q) ? k_q : k_q + 2'd1;
	end

	// Pivot selection and root argument; ties fall through to the later case.
	always_comb begin
		if (trace_q > 0) begin
			pc_d  = smtq_pkg::PV_TRACE;
			arg_d = sat_w(ONE64 + x64(trace_q));
		end else if (xbig_q) begin
			pc_d  = smtq_pkg::PV_X;
			arg_d = sat_w(ONE64 + x64(m_q[0][0]) - x64(m_q[1][1]) - x64(m_q[2][2]));
		end else if (ybig_q) begin
			pc_d  = smtq_pkg::PV_Y;
			arg_d = sat_w(ONE64 + x64(m_q[1][1]) - x64(m_q[0][0]) - x64(m_q[2][2]));
		end else begin
			pc_d  = smtq_pkg::PV_Z;
			arg_d = sat_w(ONE64 + x64(m_q[2][2]) - x64(m_q[0][0]) - x64(m_q[1][1]));
		end
		s_d = sat_w(64'(sq_root) <<< 1);
		if (s_d <= 0) begin
			s_d = W'(1);
		end
	end

	always_comb begin
		st_d      = st_q;
		item_pop  = 1'b0;
		div_start = 1'b0;
		sq_start  = 1'b0;
		out_load  = 1'b0;
		div_num   = sat_w(64'($signed(ent_q.mat[col_q][row_q])));
		div_den   = sat_w(64'($signed(ent_q.scl[col_q])));
		if (st_q == smtq_pkg::BK_QSTART || st_q == smtq_pkg::BK_QWAIT) begin
			div_num = qnum;
			div_den = s_q;
		end
		case (st_q)
			smtq_pkg::BK_IDLE: begin
				if (item_valid) begin
					item_pop = 1'b1;
					st_d     = item.zscale ? smtq_pkg::BK_OUT : smtq_pkg::BK_MSTART;
				end
			end
			smtq_pkg::BK_MSTART: begin
				div_start = 1'b1;
				st_d      = smtq_pkg::BK_MWAIT;
			end
			smtq_pkg::BK_MWAIT: begin
				if (div_done) begin
					st_d = (col_q == 2'd2 && row_q == 2'd2) ? smtq_pkg::BK_TRACE
					                                       : smtq_pkg::BK_MSTART;
				end
			end
			smtq_pkg::BK_TRACE: st_d = smtq_pkg::BK_ARG;
			smtq_pkg::BK_ARG:   st_d = smtq_pkg::BK_RSTART;
			smtq_pkg::BK_RSTART: begin
				if (arg_q <= 0) begin
					st_d = smtq_pkg::BK_OUT;
				end else begin
					sq_start = 1'b1;
					st_d     = smtq_pkg::BK_RWAIT;
				end
			end
			smtq_pkg::BK_RWAIT: begin
				if (sq_done) begin
					st_d = smtq_pkg::BK_SCALE;
				end
			end
			smtq_pkg::BK_SCALE: st_d = smtq_pkg::BK_QSTART;
			smtq_pkg::BK_QSTART: begin
				div_start = 1'b1;
				st_d      = smtq_pkg::BK_QWAIT;
			end
			smtq_pkg::BK_QWAIT: begin
				if (div_done) begin
					st_d = (k_q == 2'd2) ? smtq_pkg::BK_OUT : smtq_pkg::BK_QSTART;
				end
			end
			smtq_pkg::BK_OUT: begin
				if (!oval_q || pop) begin
					out_load = 1'b1;
					st_d     = smtq_pkg::BK_IDLE;
				end
			end
			default: st_d = smtq_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= smtq_pkg::BK_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			smtq_pkg::BK_IDLE: begin
				ent_q  <= item;
				col_q  <= 2'd0;
				row_q  <= 2'd0;
				k_q    <= 2'd0;
				pc_q   <= smtq_pkg::PV_TRACE;
				stat_q <= item.zscale ? smtq_pkg::ST_ZSCALE : smtq_pkg::ST_OK;
				for (int i = 0; i < 4; i++) begin
					q_q[i] <= '0;
				end
			end
			smtq_pkg::BK_MWAIT: begin
				if (div_done) begin
					m_q[col_q][row_q] <= div_res;
					if (row_q == 2'd2) begin
						row_q <= 2'd0;
						col_q <= col_q + 2'd1;
					end else begin
						row_q <= row_q + 2'd1;
					end
				end
			end
			smtq_pkg::BK_TRACE: begin
				trace_q <= sat_w(x64(m_q[0][0]) + x64(m_q[1][1]) + x64(m_q[2][2]));
				xbig_q  <= (m_q[0][0] > m_q[1][1]) && (m_q[0][0] > m_q[2][2]);
				ybig_q  <= (m_q[1][1] > m_q[2][2]);
				dx_q    <= sat_w(x64(m_q[1][2]) - x64(m_q[2][1]));
				dy_q    <= sat_w(x64(m_q[2][0]) - x64(m_q[0][2]));
				dz_q    <= sat_w(x64(m_q[0][1]) - x64(m_q[1][0]));
				pxy_q   <= sat_w(x64(m_q[0][1]) + x64(m_q[1][0]));
				pxz_q   <= sat_w(x64(m_q[0][2]) + x64(m_q[2][0]));
				pyz_q   <= sat_w(x64(m_q[1][2]) + x64(m_q[2][1]));
			end
			smtq_pkg::BK_ARG: begin
				pc_q  <= pc_d;
				arg_q <= arg_d;
			end
			smtq_pkg::BK_RSTART: begin
				if (arg_q <= 0) begin
					stat_q <= smtq_pkg::ST_BADARG;
				end
			end
			smtq_pkg::BK_RWAIT: begin
				if (sq_done) begin
					s_q <= s_d;
				end
			end
			smtq_pkg::BK_SCALE: begin
				q_q[pc_q] <= s_q >>> 2;
			end
			smtq_pkg::BK_QWAIT: begin
				if (div_done) begin
					q_q[tgt] <= div_res;
					k_q      <= k_q + 2'd1;
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			ow_q  <= out32(q_q[0]);
			ox_q  <= out32(q_q[1]);
			oy_q  <= out32(q_q[2]);
			oz_q  <= out32(q_q[3]);
			opc_q <= pc_q;
			ost_q <= stat_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oval_q <= 1'b0;
		end else if (out_load) begin
			oval_q <= 1'b1;
		end else if (pop) begin
			oval_q <= 1'b0;
		end
	end

	assign quat_w     = ow_q;
	assign quat_x     = ox_q;
	assign quat_y     = oy_q;
	assign quat_z     = oz_q;
	assign pivot_case = opc_q;
	assign status     = ost_q;
	assign empty      = !oval_q;

endmodule

/* rtl/scaled_matrix_to_quaternion_checker.sv */
`include "scaled_matrix_to_quaternion_assert.svh"

module scaled_matrix_to_quaternion_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               empty,
	input logic               pop,
	input logic signed [31:0] quat_w,
	input logic signed [31:0] quat_x,
	input logic signed [31:0] quat_y,
	input logic signed [31:0] quat_z,
	input logic [1:0]         pivot_case,
	input logic [1:0]         status
);

	// An error result carries an all-zero quaternion.
	`SMTQ_ASSERT_NOW(a_err_zero, (!empty && status != smtq_pkg::ST_OK), (quat_w == 0 && quat_x == 0 && quat_y == 0 && quat_z == 0), "error result with nonzero quaternion")

	// A zero scale never names a pivot.
	`SMTQ_ASSERT_NOW(a_zscale_pivot, (!empty && status == smtq_pkg::ST_ZSCALE), (pivot_case == smtq_pkg::PV_TRACE), "zero scale result with a pivot")

	// With a positive trace, w is a quarter of s, twice a positive root, and cannot be negative.
	`SMTQ_ASSERT_NOW(a_trace_w_pos, (!empty && status == smtq_pkg::ST_OK && pivot_case == smtq_pkg::PV_TRACE), (!quat_w[31]), "negative w for trace pivot")

	// A waiting result stays put until popped.
	`SMTQ_ASSERT_NEXT(a_hold, (!empty && !pop), (!empty && $stable(quat_w) && $stable(status)), "waiting result changed")

endmodule

bind scaled_matrix_to_quaternion scaled_matrix_to_quaternion_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.empty      (empty),
	.pop        (pop),
	.quat_w     (quat_w),
	.quat_x     (quat_x),
	.quat_y     (quat_y),
	.quat_z     (quat_z),
	.pivot_case (pivot_case),
	.status     (status)
);
